FILE: rtl/lfu_page_replacement_core_defines.svh
`ifndef LFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, gated off while reset is low
`define LFU_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lfu_prc check failed");

// next-cycle implication, gated off while reset is low
`define LFU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lfu_prc check failed");

`endif

FILE: rtl/lfu_prc_pkg.sv
package lfu_prc_pkg;

	localparam int FRAMES      = 8;
	localparam int PAGE_W      = 7;
	localparam int PAGES       = 1 << PAGE_W;
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_W       = 4;
	localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int ACT_W       = $clog2(FRAMES + 1);

	typedef logic [PAGE_W-1:0]      page_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
	typedef logic [ACT_W-1:0]       act_t;
	typedef logic [CFG_W-1:0]       cfg_t;

	localparam cfg_t   FRAMES_RESET = CFG_W'(3);
	localparam count_t COUNT_MAX    = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_SCAN_END,
		ST_REPLACE,
		ST_CNT_WR,
		ST_DONE
	} state_t;

	// parallel lookup over the active frames
	typedef struct packed {
		logic       hit;
		logic       empty_found;
		frame_idx_t empty_idx;
	} lookup_t;

	typedef struct packed {
		logic       en;
		frame_idx_t idx;
		page_t      page;
	} frame_wr_t;

	typedef struct packed {
		logic   re;
		page_t  raddr;
		logic   we;
		page_t  waddr;
		count_t wdata;
	} cnt_req_t;

	// zero acts as one, above the frame count acts as the frame count
	function automatic act_t active_frames(cfg_t cfg);
		act_t n;
		if (cfg == '0) begin
			n = ACT_W'(1);
		end else if (int'(cfg) > FRAMES) begin
			n = ACT_W'(FRAMES);
		end else begin
			n = ACT_W'(cfg);
		end
		return n;
	endfunction

	function automatic count_t sat_inc(count_t c);
		return (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
	endfunction

endpackage

FILE: rtl/lfu_prc_count_mem.sv
module lfu_prc_count_mem (
	input  logic                  clk,
	input  lfu_prc_pkg::cnt_req_t req,
	output lfu_prc_pkg::count_t   rdata_q
);
	import lfu_prc_pkg::*;

	count_t mem [PAGES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

endmodule

FILE: rtl/lfu_prc_frame_table.sv
module lfu_prc_frame_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfu_prc_pkg::page_t      lookup_page,
	input  lfu_prc_pkg::act_t       active,
	input  lfu_prc_pkg::frame_wr_t  wr,
	input  lfu_prc_pkg::frame_idx_t rd_idx,
	output lfu_prc_pkg::page_t      rd_page,
	output lfu_prc_pkg::lookup_t    lookup
);
	import lfu_prc_pkg::*;

	logic  valid_q [FRAMES];
	page_t page_q  [FRAMES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRAMES; j++) begin
				valid_q[j] <= 1'b0;
			end
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			page_q[wr.idx] <= wr.page;
		end
	end

	// hit compare and lowest empty frame, active frames only
	always_comb begin
		lookup = '0;
		for (int j = 0; j < FRAMES; j++) begin
			if (ACT_W'(j) < active) begin
				if (valid_q[j] && (page_q[j] == lookup_page)) begin
					lookup.hit = 1'b1;
				end
				if (!valid_q[j] && !lookup.empty_found) begin
					lookup.empty_found = 1'b1;
					lookup.empty_idx   = FRAME_IDX_W'(j);
				end
			end
		end
	end

	assign rd_page = page_q[rd_idx];

endmodule

FILE: rtl/lfu_prc_ctrl.sv
module lfu_prc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lfu_prc_pkg::page_t      page,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	input  lfu_prc_pkg::act_t       active,
	output lfu_prc_pkg::page_t      lookup_page,
	input  lfu_prc_pkg::lookup_t    lookup,
	output lfu_prc_pkg::frame_wr_t  frame_wr,
	output lfu_prc_pkg::frame_idx_t rd_idx,
	input  lfu_prc_pkg::page_t      rd_page,
	output lfu_prc_pkg::cnt_req_t   cnt_req,
	input  lfu_prc_pkg::count_t     cnt_rdata
);
	import lfu_prc_pkg::*;

	state_t     state_q, state_d;
	page_t      clr_q;
	page_t      page_q;
	logic       res_hit_q;
	frame_idx_t scan_idx_q;
	logic       cmp_vld_s1;
	frame_idx_t cmp_idx_s1;
	count_t     best_q;
	frame_idx_t victim_q;
	logic       have_q;
	logic       out_valid_q;
	logic       out_hit_q;
	logic       out_free;

	assign out_free    = !out_valid_q || !out_stall;
	assign lookup_page = page_q;
	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == PAGE_W'(PAGES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = (lookup.hit || lookup.empty_found) ? ST_CNT_WR : ST_SCAN;
			end
			ST_SCAN: begin
				if ((ACT_W'(scan_idx_q) + ACT_W'(1)) == active) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: state_d = ST_REPLACE;
			ST_REPLACE:  state_d = ST_CNT_WR;
			ST_CNT_WR:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		frame_wr = '0;
		cnt_req  = '0;
		rd_idx   = scan_idx_q;
		case (state_q)
			ST_CLEAR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = clr_q;
				cnt_req.wdata = '0;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_LOOKUP: begin
				if (lookup.hit) begin
					cnt_req.re    = 1'b1;
					cnt_req.raddr = page_q;
				end else if (lookup.empty_found) begin
					frame_wr.en   = 1'b1;
					frame_wr.idx  = lookup.empty_idx;
					frame_wr.page = page_q;
					cnt_req.re    = 1'b1;
					cnt_req.raddr = page_q;
				end
			end
			ST_SCAN: begin
				cnt_req.re    = 1'b1;
				cnt_req.raddr = rd_page;
			end
			ST_REPLACE: begin
				frame_wr.en   = 1'b1;
				frame_wr.idx  = victim_q;
				frame_wr.page = page_q;
				cnt_req.re    = 1'b1;
				cnt_req.raddr = page_q;
			end
			ST_CNT_WR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = page_q;
				cnt_req.wdata = sat_inc(cnt_rdata);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PAGE_W'(1);
			end
			if (state_q == ST_LOOKUP) begin
				have_q <= 1'b0;
			end else if (cmp_vld_s1) begin
				have_q <= 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
		if ((state_q == ST_IDLE) && in_valid) begin
			page_q <= page;
		end
		if (state_q == ST_LOOKUP) begin
			res_hit_q  <= lookup.hit;
			scan_idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_idx_q <= scan_idx_q + FRAME_IDX_W'(1);
		end
		// strict less-than keeps the lowest frame on ties
		if (cmp_vld_s1 && (!have_q || (cnt_rdata < best_q))) begin
			best_q   <= cnt_rdata;
			victim_q <= cmp_idx_s1;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_hit_q <= res_hit_q;
		end
	end

endmodule

FILE: rtl/lfu_page_replacement_core.sv
// channel  | handshake               | payload
// ---------+-------------------------+--------------------------
// in       | in_valid / in_stall     | page [6:0]
// out      | out_valid / out_stall   | hit
// cfg      | cfg_we (write only)     | cfg_data [3:0] frames_in_use
//
// hit: accept, lookup with count read, count write, result load
// miss into an empty frame: same steps, frame written at lookup; miss with all active
// frames full: victim walk with one count memory read per frame walked, then replace
// the sequencer gives the count memory at most one access per cycle, read or write
// after reset a clearing pass writes zero to all 128 counts, in_stall high
// the result sits in an output register; a stalled result only holds off
// the final load, the next transfer in can still be taken
module lfu_page_replacement_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lfu_prc_pkg::page_t   page,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 hit,
	input  logic                 cfg_we,
	input  lfu_prc_pkg::cfg_t    cfg_data
);
	import lfu_prc_pkg::*;

	cfg_t       frames_q;
	act_t       active;
	page_t      lookup_page;
	lookup_t    lookup;
	frame_wr_t  frame_wr;
	frame_idx_t rd_idx;
	page_t      rd_page;
	cnt_req_t   cnt_req;
	count_t     cnt_rdata;

	// frames_in_use register, clamped to 1..FRAMES on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_data;
		end
	end

	assign active = active_frames(frames_q);

	// sequencer: lookup, victim walk, count read-modify-write
	lfu_prc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.page        (page),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.active      (active),
		.lookup_page (lookup_page),
		.lookup      (lookup),
		.frame_wr    (frame_wr),
		.rd_idx      (rd_idx),
		.rd_page     (rd_page),
		.cnt_req     (cnt_req),
		.cnt_rdata   (cnt_rdata)
	);

	// resident pages with parallel compare
	lfu_prc_frame_table u_frames (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (lookup_page),
		.active      (active),
		.wr          (frame_wr),
		.rd_idx      (rd_idx),
		.rd_page     (rd_page),
		.lookup      (lookup)
	);

	// per-page access counts, registered read data
	lfu_prc_count_mem u_counts (
		.clk     (clk),
		.req     (cnt_req),
		.rdata_q (cnt_rdata)
	);

endmodule

FILE: rtl/lfu_prc_checker.sv
`include "lfu_page_replacement_core_defines.svh"

module lfu_prc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic hit
);

	// one item at a time: busy right after a transfer in
	`LFU_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	// no result in the cycle right after a transfer in
	`LFU_ASSERT_NEXT(a_no_early_out, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))
	// a new result only comes out of a busy cycle
	`LFU_ASSERT_IMPL(a_out_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	// stalled result holds
	`LFU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(hit))

endmodule

bind lfu_page_replacement_core lfu_prc_checker u_lfu_prc_checker (.*);
